// ===== rtl/core/efb_pkg.sv =====
// Shared types and constants for the escaped frame builder.
package efb_pkg;

    localparam logic [7:0] SOF_BYTE   = 8'hFE;
    localparam logic [7:0] EOF_BYTE   = 8'hFF;
    localparam logic [7:0] ESC_BYTE   = 8'hFE;
    localparam logic [7:0] ESC_FOR_FF = 8'hFD;
    localparam logic [7:0] ESC_FOR_FE = 8'hFC;
    localparam logic [7:0] LEN_OFFSET = 8'd4;
    localparam logic [7:0] SRC_RESET  = 8'h90;
    localparam logic [7:0] DST_RESET  = 8'h91;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_PORT = 8'd1;

    typedef struct packed {
        logic        first;
        logic        final_mark;
        logic        escaped;
        logic [7:0]  data;
        logic [7:0]  esc_code;
        logic [7:0]  len_byte;
        logic [7:0]  src_port;
        logic [7:0]  dst_port;
        logic [15:0] addr;
    } efb_desc_t;

    typedef enum logic [3:0] {
        PH_START,
        PH_SOF,
        PH_LEN,
        PH_SRC,
        PH_DST,
        PH_ALO,
        PH_AHI,
        PH_DATA0,
        PH_DATA1,
        PH_TRAIL
    } efb_phase_t;

endpackage

// ===== rtl/core/efb_if.sv =====
// Channel interfaces: payload input, line output, configuration write.
interface efb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        is_first;
    logic        is_final;
    logic [7:0]  payload_count;
    logic [15:0] remote_address;

    modport source (output valid, payload_byte, is_first, is_final, payload_count,
                    remote_address, input ready);
    modport sink (input valid, payload_byte, is_first, is_final, payload_count,
                  remote_address, output ready);
endinterface

interface efb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       run_done;
    logic       frame_done;

    modport source (output valid, line_byte, run_done, frame_done, input ready);
    modport sink (input valid, line_byte, run_done, frame_done, output ready);
endinterface

interface efb_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/efb_front.sv =====
// Front end: config registers, item classification and descriptor register.
module efb_front
    import efb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    efb_in_if.sink          payload,
    efb_cfg_if.sink         cfg,
    output efb_desc_t       desc,
    output logic            push_valid,
    input  logic            push_ready
);

    logic [7:0] src_port_reg, src_port_next;
    logic [7:0] dst_port_reg, dst_port_next;
    logic       ent_valid_reg, ent_valid_next;
    efb_desc_t  ent_reg, ent_next;
    logic       accept;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        if (cfg.valid)
        begin
            if (cfg.index == REG_SOURCE_PORT)
                src_port_next = cfg.data;
            else if (cfg.index == REG_TARGET_PORT)
                dst_port_next = cfg.data;
        end
    end

    assign payload.ready = !ent_valid_reg || push_ready;
    assign accept        = payload.valid && payload.ready;

    always_comb
    begin
        ent_next            = ent_reg;
        ent_next.first      = payload.is_first;
        ent_next.final_mark = payload.is_final;
        ent_next.escaped    = (payload.payload_byte == 8'hFF) ||
                              (payload.payload_byte == 8'hFE);
        ent_next.data       = ent_next.escaped ? ESC_BYTE : payload.payload_byte;
        ent_next.esc_code   = (payload.payload_byte == 8'hFF) ? ESC_FOR_FF : ESC_FOR_FE;
        ent_next.len_byte   = payload.payload_count + LEN_OFFSET;
        ent_next.src_port   = src_port_reg;
        ent_next.dst_port   = dst_port_reg;
        ent_next.addr       = payload.remote_address;
    end

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (accept)
            ent_valid_next = 1'b1;
        else if (push_ready)
            ent_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_port_reg  <= SRC_RESET;
            dst_port_reg  <= DST_RESET;
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            src_port_reg  <= src_port_next;
            dst_port_reg  <= dst_port_next;
            ent_valid_reg <= ent_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ent_reg <= ent_next;
    end

    assign desc       = ent_reg;
    assign push_valid = ent_valid_reg;

endmodule

// ===== rtl/core/efb_queue.sv =====
// Two-entry descriptor queue between front and back.
module efb_queue
    import efb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  efb_desc_t wr_desc,
    input  logic      wr_valid,
    output logic      wr_ready,
    output efb_desc_t rd_desc,
    output logic      rd_valid,
    input  logic      rd_pop
);

    efb_desc_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;

    assign wr_ready = (count_reg != 2'd2);
    assign do_push  = wr_valid && wr_ready;
    assign rd_valid = (count_reg != 2'd0);
    assign rd_desc  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ rd_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, rd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_desc;
    end

endmodule

// ===== rtl/core/efb_back.sv =====
// Back end: byte sequencer with registered line output.
module efb_back
    import efb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  efb_desc_t desc,
    input  logic      desc_valid,
    output logic      pop,
    efb_out_if.source line
);

    efb_phase_t step_reg, step_next;
    efb_phase_t cur;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       run_reg, run_next;
    logic       frame_reg, frame_next;
    logic       load;
    logic       last;

    assign load = desc_valid && (!out_valid_reg || line.ready);
    assign cur  = (step_reg == PH_START) ? (desc.first ? PH_SOF : PH_DATA0) : step_reg;

    // byte and flags for the current phase
    always_comb
    begin
        byte_next  = desc.data;
        frame_next = 1'b0;
        last       = 1'b0;
        unique case (cur)
            PH_SOF:   byte_next = SOF_BYTE;
            PH_LEN:   byte_next = desc.len_byte;
            PH_SRC:   byte_next = desc.src_port;
            PH_DST:   byte_next = desc.dst_port;
            PH_ALO:   byte_next = desc.addr[7:0];
            PH_AHI:   byte_next = desc.addr[15:8];
            PH_DATA0:
            begin
                byte_next = desc.data;
                last      = !desc.escaped && !desc.final_mark;
            end
            PH_DATA1:
            begin
                byte_next = desc.esc_code;
                last      = !desc.final_mark;
            end
            PH_TRAIL:
            begin
                byte_next  = EOF_BYTE;
                frame_next = 1'b1;
                last       = 1'b1;
            end
            default:  byte_next = desc.data;
        endcase
        run_next = last;
        pop      = load && last;
    end

    // next phase
    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            if (last)
                step_next = PH_START;
            else
            begin
                unique case (cur)
                    PH_SOF:   step_next = PH_LEN;
                    PH_LEN:   step_next = PH_SRC;
                    PH_SRC:   step_next = PH_DST;
                    PH_DST:   step_next = PH_ALO;
                    PH_ALO:   step_next = PH_AHI;
                    PH_AHI:   step_next = PH_DATA0;
                    PH_DATA0: step_next = desc.escaped ? PH_DATA1 : PH_TRAIL;
                    PH_DATA1: step_next = PH_TRAIL;
                    default:  step_next = PH_START;
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (line.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= byte_next;
            run_reg   <= run_next;
            frame_reg <= frame_next;
        end
    end

    assign line.valid      = out_valid_reg;
    assign line.line_byte  = byte_reg;
    assign line.run_done   = run_reg;
    assign line.frame_done = frame_reg;

    a_trailer_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        line.valid && line.frame_done |-> line.run_done && (line.line_byte == EOF_BYTE))
        else $error("trailer byte without run end");

    a_mid_item_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != PH_START |-> desc_valid)
        else $error("sequencer mid item with empty queue");

    a_pop_resets_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> step_reg == PH_START)
        else $error("sequencer not back at item start after pop");

endmodule

// ===== rtl/core/escaped_frame_builder.sv =====
// Top level: byte-stuffing framer with header and trailer insertion.
// An accepted item reaches the line through the front reg, the queue and the out reg.
// Throughput: one line byte per cycle while line.ready holds; an item emits 1 to 9 bytes,
// one sequencer step each, so mid-frame unescaped payload bytes sustain one item per cycle.
// The two-entry queue lets the front keep accepting while the sequencer emits a header, until it fills.
// Reset: asynchronous active low; clears control state, ports reset to 0x90 and 0x91.
module escaped_frame_builder
    import efb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    efb_in_if.sink    payload,
    efb_cfg_if.sink   cfg,
    efb_out_if.source line
);

    efb_desc_t front_desc;
    efb_desc_t head_desc;
    logic      push_valid;
    logic      q_ready;
    logic      head_valid;
    logic      head_pop;

    efb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .payload    (payload),
        .cfg        (cfg),
        .desc       (front_desc),
        .push_valid (push_valid),
        .push_ready (q_ready)
    );

    efb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_desc  (front_desc),
        .wr_valid (push_valid),
        .wr_ready (q_ready),
        .rd_desc  (head_desc),
        .rd_valid (head_valid),
        .rd_pop   (head_pop)
    );

    efb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (head_desc),
        .desc_valid (head_valid),
        .pop        (head_pop),
        .line       (line)
    );

endmodule

// ===== dv/tb_escaped_frame_builder.sv =====
// Testbench for escaped_frame_builder: directed and random framing traffic, checked against a predictor.
module tb_escaped_frame_builder;
    import efb_pkg::*;

    localparam int RANDOM_ITEMS = 350;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP   = 8'hFF;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_first;
        logic        is_final;
        logic [7:0]  payload_count;
        logic [15:0] remote_address;
    } payload_item_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_done;
        logic       frame_done;
    } line_item_t;

    logic clk = 1'b0;
    logic rst_n;

    efb_in_if  in_ch ();
    efb_out_if out_ch ();
    efb_cfg_if cfg_ch ();

    escaped_frame_builder uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (in_ch),
        .cfg     (cfg_ch),
        .line    (out_ch)
    );

    line_item_t expected_line[$];
    logic [7:0] src_port_now;
    logic [7:0] dst_port_now;
    int         mismatches;
    bit         idling_on;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        if (mismatches < 40)
            $display("%0t: mismatch on %s: expected %02h, got %02h", $realtime, what, want, got);
        mismatches++;
    endtask

    function automatic void frame_line_bytes(input payload_item_t it);
        line_item_t run[$];
        logic [7:0] len_byte;
        len_byte = it.payload_count + LEN_OFFSET;
        if (it.is_first)
        begin
            run.push_back('{SOF_BYTE, 1'b0, 1'b0});
            run.push_back('{len_byte, 1'b0, 1'b0});
            run.push_back('{src_port_now, 1'b0, 1'b0});
            run.push_back('{dst_port_now, 1'b0, 1'b0});
            run.push_back('{it.remote_address[7:0], 1'b0, 1'b0});
            run.push_back('{it.remote_address[15:8], 1'b0, 1'b0});
        end
        if (it.payload_byte == 8'hFF)
        begin
            run.push_back('{ESC_BYTE, 1'b0, 1'b0});
            run.push_back('{ESC_FOR_FF, 1'b0, 1'b0});
        end
        else if (it.payload_byte == 8'hFE)
        begin
            run.push_back('{ESC_BYTE, 1'b0, 1'b0});
            run.push_back('{ESC_FOR_FE, 1'b0, 1'b0});
        end
        else
            run.push_back('{it.payload_byte, 1'b0, 1'b0});
        if (it.is_final)
            run.push_back('{EOF_BYTE, 1'b0, 1'b1});
        run[run.size()-1].run_done = 1'b1;
        foreach (run[i])
            expected_line.push_back(run[i]);
    endfunction

    // line check first, then prediction of the item accepted at this edge
    always @(posedge clk)
    begin
        line_item_t want;
        payload_item_t got_in;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_line.size() == 0)
                    report_mismatch("unexpected line item", 8'h00, out_ch.line_byte);
                else
                begin
                    want = expected_line.pop_front();
                    if (out_ch.line_byte !== want.line_byte)
                        report_mismatch("line_byte", want.line_byte, out_ch.line_byte);
                    if (out_ch.run_done !== want.run_done)
                        report_mismatch("run_done", {7'd0, want.run_done}, {7'd0, out_ch.run_done});
                    if (out_ch.frame_done !== want.frame_done)
                        report_mismatch("frame_done", {7'd0, want.frame_done},
                                        {7'd0, out_ch.frame_done});
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                got_in = '{in_ch.payload_byte, in_ch.is_first, in_ch.is_final,
                           in_ch.payload_count, in_ch.remote_address};
                frame_line_bytes(got_in);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_SOURCE_PORT: src_port_now = cfg_ch.data;
                    REG_TARGET_PORT: dst_port_now = cfg_ch.data;
                    default: ;
                endcase
            end
        end
    end

    // line sink with random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(input payload_item_t it);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_ch.payload_byte   <= it.payload_byte;
        in_ch.is_first       <= it.is_first;
        in_ch.is_final       <= it.is_final;
        in_ch.payload_count  <= it.payload_count;
        in_ch.remote_address <= it.remote_address;
        in_ch.valid          <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_line();
        in_ch.valid <= 1'b0;
        while (expected_line.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_frame(input int len, input logic [15:0] addr, input logic [7:0] count);
        payload_item_t it;
        int pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 7);
            it.payload_byte   = (pick == 0) ? 8'hFF : (pick == 1) ? 8'hFE : 8'($urandom);
            it.is_first       = (i == 0);
            it.is_final       = (i == len - 1);
            it.payload_count  = (i == 0) ? count : 8'($urandom);
            it.remote_address = (i == 0) ? addr : 16'($urandom);
            send_item(it);
        end
    endtask

    task automatic test_reset_ports();
        send_item('{8'h55, 1'b1, 1'b1, 8'd1, 16'hA5C3});
    endtask

    task automatic test_escape_codes();
        send_item('{8'h00, 1'b1, 1'b0, 8'd7, 16'h0000});
        send_item('{8'hFF, 1'b0, 1'b0, 8'd0, 16'h0000});
        send_item('{8'hFE, 1'b0, 1'b0, 8'd0, 16'h0000});
        send_item('{8'hFD, 1'b0, 1'b0, 8'd0, 16'h0000});
        send_item('{8'hFC, 1'b0, 1'b0, 8'd0, 16'h0000});
        send_item('{8'h7F, 1'b0, 1'b0, 8'd0, 16'h0000});
        send_item('{8'h80, 1'b0, 1'b1, 8'd0, 16'h0000});
    endtask

    task automatic test_length_extremes();
        // count wraps in the 8-bit length byte
        send_item('{8'hFF, 1'b1, 1'b1, 8'd0, 16'hFFFF});
        send_item('{8'h01, 1'b1, 1'b1, 8'd251, 16'h0000});
        send_item('{8'hFE, 1'b1, 1'b1, 8'd252, 16'h8001});
        send_item('{8'hAA, 1'b1, 1'b1, 8'd255, 16'h7FFE});
    endtask

    task automatic test_loose_marks();
        send_item('{8'h01, 1'b0, 1'b1, 8'd9, 16'h4321});
        send_item('{8'h02, 1'b1, 1'b0, 8'd3, 16'h1234});
        send_item('{8'h03, 1'b1, 1'b0, 8'd40, 16'hBEEF});
        send_item('{8'h04, 1'b0, 1'b1, 8'hFF, 16'hFFFF});
    endtask

    task automatic test_port_registers();
        drain_line();
        write_reg(REG_SOURCE_PORT, 8'h00);
        write_reg(REG_TARGET_PORT, 8'hFF);
        write_reg(REG_INDEX_SPARE, 8'h3C);
        send_item('{8'h10, 1'b1, 1'b1, 8'd1, 16'h00FF});
        drain_line();
        write_reg(REG_SOURCE_PORT, 8'hFF);
        write_reg(REG_TARGET_PORT, 8'h00);
        write_reg(REG_INDEX_TOP, 8'hA5);
        send_item('{8'h20, 1'b1, 1'b1, 8'd2, 16'hFF00});
        drain_line();
        write_reg(REG_INDEX_SPARE, 8'h00);
        send_item('{8'hFF, 1'b1, 1'b0, 8'd1, 16'h5A5A});
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase;
        int len;
        payload_item_t it;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_line();
            idling_on = (sent < RANDOM_ITEMS * 3 / 4) && (phase % 3 != 2);
            case ($urandom_range(0, 2))
                0: write_reg(REG_SOURCE_PORT, 8'h00);
                1: write_reg(REG_SOURCE_PORT, 8'hFF);
                default: write_reg(REG_SOURCE_PORT, 8'($urandom));
            endcase
            case ($urandom_range(0, 2))
                0: write_reg(REG_TARGET_PORT, 8'h00);
                1: write_reg(REG_TARGET_PORT, 8'hFF);
                default: write_reg(REG_TARGET_PORT, 8'($urandom));
            endcase
            repeat (6)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    it = payload_item_t'(34'({$urandom, $urandom}));
                    send_item(it);
                    sent++;
                end
                else
                begin
                    len = ($urandom_range(0, 39) == 0) ? $urandom_range(1, 60)
                                                       : $urandom_range(1, 8);
                    send_frame(len, 16'($urandom), 8'(len));
                    sent += len;
                end
            end
            phase++;
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("tb_escaped_frame_builder: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        mismatches = 0;
        idling_on = 1'b1;
        src_port_now = SRC_RESET;
        dst_port_now = DST_RESET;
        in_ch.valid = 1'b0;
        in_ch.payload_byte = 8'h00;
        in_ch.is_first = 1'b0;
        in_ch.is_final = 1'b0;
        in_ch.payload_count = 8'h00;
        in_ch.remote_address = 16'h0000;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SOURCE_PORT;
        cfg_ch.data = 8'h00;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_reset_ports();
        test_escape_codes();
        test_length_extremes();
        test_loose_marks();
        test_port_registers();
        test_random_traffic();

        idling_on = 1'b0;
        drain_line();
        if (mismatches == 0)
            $display("tb_escaped_frame_builder: PASS");
        else
            $display("tb_escaped_frame_builder: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/efb_pkg.sv
rtl/core/efb_if.sv
rtl/core/efb_front.sv
rtl/core/efb_queue.sv
rtl/core/efb_back.sv
rtl/core/escaped_frame_builder.sv
dv/tb_escaped_frame_builder.sv
